/* src/smbd_pkg.sv */
// Package for the schema message byte decoder.
// Holds parse phases, record kinds, error codes and the record struct.
// No dependencies.
package smbd_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueDepthDefault = QueueDepth;

    typedef enum logic [3:0] {
        PH_PREFIX, PH_MSGID, PH_CORR, PH_STREAM, PH_SEQ, PH_COMP, PH_FCOUNT,
        PH_FID, PH_VCOUNT, PH_TYPE, PH_VALUE, PH_LEN, PH_PAYLOAD, PH_DONE,
        PH_DISCARD
    } t_phase;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_FIELD   = 3'd1;
    localparam logic [2:0] KIND_VALUE   = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [1:0] ERR_SHORT     = 2'd0;
    localparam logic [1:0] ERR_MAGIC     = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    localparam logic [3:0] TYPE_BOOL   = 4'd0;
    localparam logic [3:0] TYPE_FLOAT  = 4'd5;
    localparam logic [3:0] TYPE_STRING = 4'd7;
    localparam logic [3:0] TYPE_BYTES  = 4'd8;

    // Record request from the front part to the back part.
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] msg_ident;
        logic [63:0] corr_ident;
        logic [63:0] strm_ident;
        logic [31:0] sequence_number;
        logic        compressed_flag;
        logic [31:0] field_ident;
        logic [31:0] item_count;
        logic [3:0]  value_type;
        logic [63:0] value_bits;
        logic        widen;
        logic [1:0]  error_code;
        logic        ends_message;
    } t_rec;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'h53;
            2'd1: b = 8'h48;
            2'd2: b = 8'h50;
            2'd3: b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/smbd_front.sv */
// Front part: accepts bytes, tracks the frame phase and builds record requests.
// Depends on smbd_pkg.
module smbd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output logic           o_have,
    output smbd_pkg::t_rec o_rec
);
    import smbd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_word, n_word;
    logic [3:0]  r_seen, n_seen;
    logic        r_mis, n_mis;
    logic [31:0] r_mid, n_mid;
    logic [63:0] r_corr, n_corr;
    logic [63:0] r_strm, n_strm;
    logic [31:0] r_seq, n_seq;
    logic        r_comp, n_comp;
    logic [31:0] r_fl, n_fl, r_vl, n_vl, r_pl, n_pl, r_cf, n_cf;
    logic [3:0]  r_ct, n_ct;

    logic [63:0] w;
    logic [3:0]  len;
    logic        done;
    logic [31:0] fl_dec, vl_dec;

    // Fold the byte into the word at its position
    assign w = r_word | ({56'd0, i_data_byte} << {r_pos, 3'b000});
    assign fl_dec = r_fl - 32'd1;
    assign vl_dec = r_vl - 32'd1;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_word = r_word; n_seen = r_seen;
        n_mis = r_mis; n_mid = r_mid; n_corr = r_corr; n_strm = r_strm;
        n_seq = r_seq; n_comp = r_comp; n_fl = r_fl; n_vl = r_vl; n_pl = r_pl;
        n_cf = r_cf; n_ct = r_ct;
        o_have = 1'b0;
        o_rec = '0;
        len = 4'd4;
        case (r_phase)
            PH_MSGID, PH_SEQ, PH_FCOUNT, PH_FID, PH_VCOUNT, PH_LEN: len = 4'd4;
            PH_CORR, PH_STREAM: len = 4'd8;
            PH_VALUE: len = (r_ct == TYPE_BOOL) ? 4'd1 : (r_ct == TYPE_FLOAT) ? 4'd4 : 4'd8;
            default: len = 4'd4;
        endcase
        done = ({1'b0, r_pos} + 4'd1) >= len;
        case (r_phase)
            PH_PREFIX, PH_COMP, PH_TYPE, PH_PAYLOAD, PH_DONE, PH_DISCARD: ;
            default: begin
                if (done) begin
                    n_pos = '0;
                    n_word = '0;
                end else begin
                    n_pos = r_pos + 3'd1;
                    n_word = w;
                end
            end
        endcase
        o_rec.msg_ident = r_mid; o_rec.corr_ident = r_corr;
        o_rec.strm_ident = r_strm; o_rec.sequence_number = r_seq;
        o_rec.compressed_flag = r_comp;
        case (r_phase)
            PH_PREFIX: begin
                if (!r_seen[3] && !r_seen[2] && i_data_byte != magic_byte(r_seen[1:0]))
                    n_mis = 1'b1;
                n_seen = r_seen + 4'd1;
                if (r_seen == 4'd11)
                    n_phase = (n_mis) ? PH_DISCARD : PH_MSGID;
            end
            PH_MSGID: if (done) begin n_mid = w[31:0]; n_phase = PH_CORR; end
            PH_CORR: if (done) begin n_corr = w; n_phase = PH_STREAM; end
            PH_STREAM: if (done) begin n_strm = w; n_phase = PH_SEQ; end
            PH_SEQ: if (done) begin n_seq = w[31:0]; n_phase = PH_COMP; end
            PH_COMP: begin
                n_comp = (i_data_byte != 8'd0);
                n_phase = PH_FCOUNT;
            end
            PH_FCOUNT: if (done) begin
                n_fl = w[31:0];
                o_have = 1'b1;
                o_rec.kind = KIND_HEADER;
                o_rec.item_count = w[31:0];
                n_phase = (w[31:0] == 32'd0) ? PH_DONE : PH_FID;
            end
            PH_FID: if (done) begin n_cf = w[31:0]; n_phase = PH_VCOUNT; end
            PH_VCOUNT: if (done) begin
                n_vl = w[31:0];
                o_have = 1'b1;
                o_rec.kind = KIND_FIELD;
                o_rec.field_ident = r_cf;
                o_rec.item_count = w[31:0];
                if (w[31:0] == 32'd0) begin
                    n_fl = fl_dec;
                    n_phase = (fl_dec == 32'd0) ? PH_DONE : PH_FID;
                end else begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (i_data_byte > 8'd8) begin
                    n_vl = vl_dec;
                    if (vl_dec == 32'd0) begin
                        n_fl = fl_dec;
                        n_phase = (fl_dec == 32'd0) ? PH_DONE : PH_FID;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end else begin
                    n_ct = i_data_byte[3:0];
                    n_phase = (i_data_byte[3:0] == TYPE_STRING ||
                               i_data_byte[3:0] == TYPE_BYTES) ? PH_LEN : PH_VALUE;
                end
            end
            PH_VALUE: if (done) begin
                o_have = 1'b1;
                o_rec.kind = KIND_VALUE;
                o_rec.field_ident = r_cf;
                o_rec.value_type = r_ct;
                o_rec.value_bits = (r_ct == TYPE_BOOL) ? {63'd0, w != 64'd0} : w;
                o_rec.widen = (r_ct == TYPE_FLOAT);
                n_vl = vl_dec;
                if (vl_dec == 32'd0) begin
                    n_fl = fl_dec;
                    n_phase = (fl_dec == 32'd0) ? PH_DONE : PH_FID;
                end else begin
                    n_phase = PH_TYPE;
                end
            end
            PH_LEN: if (done) begin
                n_pl = w[31:0];
                o_have = 1'b1;
                o_rec.kind = KIND_VALUE;
                o_rec.field_ident = r_cf;
                o_rec.item_count = w[31:0];
                o_rec.value_type = r_ct;
                if (w[31:0] == 32'd0) begin
                    n_vl = vl_dec;
                    if (vl_dec == 32'd0) begin
                        n_fl = fl_dec;
                        n_phase = (fl_dec == 32'd0) ? PH_DONE : PH_FID;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_have = 1'b1;
                o_rec.kind = KIND_PAYLOAD;
                o_rec.field_ident = r_cf;
                o_rec.value_type = r_ct;
                o_rec.value_bits = {56'd0, i_data_byte};
                n_pl = r_pl - 32'd1;
                if (r_pl == 32'd1) begin
                    n_vl = vl_dec;
                    if (vl_dec == 32'd0) begin
                        n_fl = fl_dec;
                        n_phase = (fl_dec == 32'd0) ? PH_DONE : PH_FID;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            default: ;
        endcase
        o_rec.ends_message = o_have && (r_phase != PH_DONE) && (n_phase == PH_DONE);
        // Final byte: errors override, then drop all state
        if (i_last_byte) begin
            if (n_seen < 4'd12 || n_mis || n_phase != PH_DONE) begin
                o_rec = '0;
                o_have = 1'b1;
                o_rec.kind = KIND_ERROR;
                o_rec.ends_message = 1'b1;
                o_rec.error_code = (n_seen < 4'd12) ? ERR_SHORT :
                                   (n_mis) ? ERR_MAGIC : ERR_TRUNCATED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_phase <= PH_PREFIX; r_pos <= '0; r_word <= '0; r_seen <= '0;
            r_mis <= 1'b0; r_mid <= '0; r_corr <= '0; r_strm <= '0; r_seq <= '0;
            r_comp <= 1'b0; r_fl <= '0; r_vl <= '0; r_pl <= '0; r_cf <= '0;
            r_ct <= '0;
        end else if (i_take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_word <= n_word; r_seen <= n_seen;
            r_mis <= n_mis; r_mid <= n_mid; r_corr <= n_corr; r_strm <= n_strm;
            r_seq <= n_seq; r_comp <= n_comp; r_fl <= n_fl; r_vl <= n_vl;
            r_pl <= n_pl; r_cf <= n_cf; r_ct <= n_ct;
        end
    end

endmodule

/* src/smbd_queue.sv */
// Short queue of record requests between the front and back parts.
// Depends on smbd_pkg.
module smbd_queue #(
    parameter int Depth = smbd_pkg::QueueDepthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smbd_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output smbd_pkg::t_rec o_rec
);
    import smbd_pkg::*;

    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    t_rec          r_mem [Depth];
    logic [Aw-1:0] r_wr, r_rd;
    logic [Aw:0]   r_cnt;

    assign o_full  = (r_cnt == Aw'(0) + (Aw+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rd];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr] <= i_rec;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full)
                r_wr <= (r_wr == Aw'(Depth - 1)) ? '0 : r_wr + Aw'(1);
            if (i_pop && !o_empty)
                r_rd <= (r_rd == Aw'(Depth - 1)) ? '0 : r_rd + Aw'(1);
            r_cnt <= r_cnt + (Aw+1)'(i_push && !o_full) - (Aw+1)'(i_pop && !o_empty);
        end
    end

endmodule

/* src/smbd_back.sv */
// Back part: widens floats and holds the finished record in an output register.
// Depends on smbd_pkg.
module smbd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  smbd_pkg::t_rec i_rec,
    output logic           o_take,
    input  logic           i_pop,
    output logic           o_empty,
    output smbd_pkg::t_rec o_rec
);
    import smbd_pkg::*;

    logic        r_full;
    t_rec        r_rec, n_rec;
    logic [22:0] m, mn;
    logic [7:0]  e;
    logic [4:0]  lz;
    logic [10:0] ex;

    assign o_take  = i_valid && (!r_full || i_pop);
    assign o_empty = !r_full;
    assign o_rec   = r_rec;

    // Widen a single float to double
    always_comb begin
        n_rec = i_rec;
        m = i_rec.value_bits[22:0];
        e = i_rec.value_bits[30:23];
        // Leading zeros of the fraction: the highest set bit wins
        lz = '0;
        for (int k = 0; k <= 22; k++) begin
            if (m[k]) lz = 5'(22 - k);
        end
        mn = m << (lz + 5'd1);
        ex = 11'd1023 - 11'd126 - 11'd1 - {6'd0, lz};
        if (i_rec.widen) begin
            if (e == 8'hFF) begin
                // Infinity keeps a zero fraction; NaN comes out quiet
                n_rec.value_bits = {i_rec.value_bits[31], 11'h7FF, (m != '0) | m[22],
                                    m[21:0], 29'd0};
            end else if (e == 8'd0) begin
                if (m == '0) n_rec.value_bits = {i_rec.value_bits[31], 63'd0};
                else n_rec.value_bits = {i_rec.value_bits[31], ex, mn, 29'd0};
            end else begin
                n_rec.value_bits = {i_rec.value_bits[31], {3'd0, e} + 11'd896, m, 29'd0};
            end
        end
    end

    // Hold the result until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else if (o_take) r_full <= 1'b1;
        else if (i_pop) r_full <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_rec <= n_rec;
    end

endmodule

/* src/schema_message_byte_decoder.sv */
// Schema message byte decoder: one byte accepted per cycle when not full.
// A record passes through the queue and then the back part's output register before it reaches the result ports.
// Throughput: one byte per clock; the front stalls only when the queue fills.
// Reset: synchronous active low; phase, counters and queue pointers clear.
// The last byte of a buffer returns the parse state to its reset values.
module schema_message_byte_decoder #(
    parameter int QueueDepth = smbd_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_record_kind,
    output logic [31:0] o_message_id,
    output logic [63:0] o_correlation_id,
    output logic [63:0] o_stream_id,
    output logic [31:0] o_sequence_number,
    output logic        o_compressed_flag,
    output logic [31:0] o_field_ident,
    output logic [31:0] o_item_count,
    output logic [3:0]  o_value_type,
    output logic [63:0] o_value_bits,
    output logic [1:0]  o_error_code,
    output logic        o_ends_message
);
    import smbd_pkg::*;

    logic take, have, q_empty, b_take;
    t_rec f_rec, q_rec, o_rec;

    assign take = push && !full;

    smbd_front u_front (.i_clk, .i_rst_n, .i_take(take), .i_data_byte, .i_last_byte,
                        .o_have(have), .o_rec(f_rec));

    smbd_queue #(.Depth(QueueDepth)) u_queue (.i_clk, .i_rst_n, .i_push(take && have),
        .i_rec(f_rec), .o_full(full), .i_pop(b_take), .o_empty(q_empty), .o_rec(q_rec));

    smbd_back u_back (.i_clk, .i_rst_n, .i_valid(!q_empty), .i_rec(q_rec),
                      .o_take(b_take), .i_pop(pop), .o_empty(empty), .o_rec(o_rec));

    assign o_record_kind = o_rec.kind;
    assign o_message_id = o_rec.msg_ident;
    assign o_correlation_id = o_rec.corr_ident;
    assign o_stream_id = o_rec.strm_ident;
    assign o_sequence_number = o_rec.sequence_number;
    assign o_compressed_flag = o_rec.compressed_flag;
    assign o_field_ident = o_rec.field_ident;
    assign o_item_count = o_rec.item_count;
    assign o_value_type = o_rec.value_type;
    assign o_value_bits = o_rec.value_bits;
    assign o_error_code = o_rec.error_code;
    assign o_ends_message = o_rec.ends_message;

    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_ERROR) |-> o_ends_message)
        else $error("error record without end mark");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !q_empty)
        else $error("queue full yet empty");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!empty) && $past(!pop) && $past(i_rst_n)) |-> !empty)
        else $error("result lost");

endmodule
